>>> hw/rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Request and result layouts, field widths, status and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  localparam int TIME_W  = 20;           // timeout register width
  localparam int ECHO_W  = TIME_W + 1;   // elapsed tick counter / echo width
  localparam int DIV_W   = 8;            // us_per_cm divisor width
  localparam int DIST_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [ECHO_W-1:0] TRIG_LOW_TICKS  = ECHO_W'(2);
  localparam logic [ECHO_W-1:0] TRIG_HIGH_TICKS = ECHO_W'(10);

  localparam logic [TIME_W-1:0] TIMEOUT_RST = TIME_W'(30000);
  localparam logic [DIV_W-1:0]  US_CM_RST   = DIV_W'(58);
  localparam logic [DIST_W-1:0] MAX_CM_RST  = DIST_W'(400);

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_US_CM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CM  = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_TIMEOUT = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } uer_in_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        status;
    logic [DIST_W-1:0] distance_cm;
    logic [ECHO_W-1:0] echo_width_us;
  } uer_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/uer_div.sv
// ----------------------------------------------------------------------------
// uer_div: bit-serial restoring divider
// Divides the echo width by the 8-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [uer_pkg::ECHO_W-1:0] dividend,
  input  wire logic [uer_pkg::DIV_W-1:0]  divisor,
  output logic                            done,
  output logic [uer_pkg::ECHO_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(uer_pkg::ECHO_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(uer_pkg::ECHO_W - 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [uer_pkg::DIV_W-1:0]   rem_r;
  logic [uer_pkg::DIV_W-1:0]   dvs_r;
  logic [uer_pkg::ECHO_W-1:0]  quo_r;
  logic [uer_pkg::DIV_W:0]     trial;
  logic [uer_pkg::DIV_W:0]     diff;
  logic                        fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_r, quo_r[uer_pkg::ECHO_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[uer_pkg::DIV_W-1:0] : trial[uer_pkg::DIV_W-1:0];
      quo_r <= {quo_r[uer_pkg::ECHO_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> hw/rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: ultrasonic time-of-flight ranging sequencer
// One request per microsecond tick, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per tick, carrying start_req and the echo sample.
//   out_*  : one result per request: trigger level, busy, done, status,
//            distance and echo width (the last three valid with done).
//   cfg_*  : register writes (0 echo timeout, 1 us_per_cm, 2 max_distance_cm),
//            always ready; write them only while the block is idle.
// Latency: a request's result is valid in the cycle after it is taken.
//   The request that sees the echo fall starts the serial divider (unless
//   the divisor is zero), which makes one quotient bit per cycle over the
//   21-bit width; its result shows once the divider is done. Otherwise one
//   request per cycle while results drain; none is taken while it divides.
// A new request is taken while the result register is empty or being
// drained; a stalled receiver holds the result and blocks the input.
// Reset: phase idle, counter zero, registers at their defaults, no result.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire uer_pkg::uer_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output uer_pkg::uer_out_t                  out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [uer_pkg::TIME_W-1:0]    cfg_data
);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_LOW  = 5'b00010,
    PH_HIGH = 5'b00100,
    PH_RISE = 5'b01000,
    PH_FALL = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    CS_RUN = 2'b01,
    CS_DIV = 2'b10
  } ctrl_t;

  localparam int EW = uer_pkg::ECHO_W;
  localparam int DW = uer_pkg::DIST_W;

  phase_t                        phase_r, phase_nxt;
  ctrl_t                         ctrl_r;
  logic [EW-1:0]                 elapsed_r, elapsed_nxt;
  logic [uer_pkg::TIME_W-1:0]    timeout_r;
  logic [uer_pkg::DIV_W-1:0]     us_cm_r;
  logic [DW-1:0]                 max_cm_r;
  logic                          out_valid_r;
  uer_pkg::uer_out_t             out_data_r;
  uer_pkg::uer_out_t             res;
  logic                          div_start;
  logic                          div_done;
  logic [EW-1:0]                 quotient;
  logic [EW-1:0]                 inc;
  logic                          timed_out;
  logic                          in_acc;
  logic [DW-1:0]                 dist_sat;

  function automatic logic [1:0] range_status(input logic [DW-1:0] d,
                                              input logic [DW-1:0] dmax);
    range_status = (d == '0 || d > dmax) ? uer_pkg::STAT_RANGE : uer_pkg::STAT_OK;
  endfunction

  assign in_ready  = (ctrl_r == CS_RUN) && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign inc       = elapsed_r + EW'(1);
  assign timed_out = (elapsed_r >= {1'b0, timeout_r});
  assign dist_sat  = (quotient > EW'({DW{1'b1}})) ? {DW{1'b1}} : quotient[DW-1:0];

  uer_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed_r),
    .divisor  (us_cm_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    res         = '0;
    div_start   = 1'b0;
    unique case (phase_r)
      PH_LOW: begin
        res.busy_res = 1'b1;
        elapsed_nxt  = inc;
        if (inc >= uer_pkg::TRIG_LOW_TICKS) begin
          phase_nxt   = PH_HIGH;
          elapsed_nxt = '0;
        end
      end
      PH_HIGH: begin
        res.busy_res      = 1'b1;
        res.trigger_level = 1'b1;
        elapsed_nxt       = inc;
        if (inc >= uer_pkg::TRIG_HIGH_TICKS) begin
          phase_nxt   = PH_RISE;
          elapsed_nxt = '0;
        end
      end
      PH_RISE: begin
        if (in_data.echo_level) begin
          res.busy_res = 1'b1;
          phase_nxt    = PH_FALL;
          elapsed_nxt  = EW'(1);
        end else if (timed_out) begin
          res.done_res = 1'b1;
          res.status   = uer_pkg::STAT_TIMEOUT;
          phase_nxt    = PH_IDLE;
          elapsed_nxt  = '0;
        end else begin
          res.busy_res = 1'b1;
          elapsed_nxt  = inc;
        end
      end
      PH_FALL: begin
        if (!in_data.echo_level) begin
          res.done_res      = 1'b1;
          res.echo_width_us = elapsed_r;
          // a zero divisor saturates without running the divider
          if (us_cm_r == '0) begin
            res.distance_cm = {DW{1'b1}};
            res.status      = range_status({DW{1'b1}}, max_cm_r);
          end else begin
            div_start = in_acc;
          end
          phase_nxt   = PH_IDLE;
          elapsed_nxt = '0;
        end else if (timed_out) begin
          res.done_res = 1'b1;
          res.status   = uer_pkg::STAT_TIMEOUT;
          phase_nxt    = PH_IDLE;
          elapsed_nxt  = '0;
        end else begin
          res.busy_res = 1'b1;
          elapsed_nxt  = inc;
        end
      end
      default: begin
        phase_nxt   = PH_IDLE;
        elapsed_nxt = '0;
        if (in_data.start_req) begin
          res.busy_res = 1'b1;
          phase_nxt    = PH_LOW;
          elapsed_nxt  = EW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      elapsed_r   <= '0;
      ctrl_r      <= CS_RUN;
      out_valid_r <= 1'b0;
      timeout_r   <= uer_pkg::TIMEOUT_RST;
      us_cm_r     <= uer_pkg::US_CM_RST;
      max_cm_r    <= uer_pkg::MAX_CM_RST;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          uer_pkg::REG_TIMEOUT: timeout_r <= cfg_data;
          uer_pkg::REG_US_CM:   us_cm_r   <= cfg_data[uer_pkg::DIV_W-1:0];
          uer_pkg::REG_MAX_CM:  max_cm_r  <= cfg_data[DW-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_r     <= phase_nxt;
        elapsed_r   <= elapsed_nxt;
        out_valid_r <= !div_start;
        if (div_start) begin
          ctrl_r <= CS_DIV;
        end
      end else if (ctrl_r == CS_DIV && div_done) begin
        ctrl_r      <= CS_RUN;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res;
    end else if (ctrl_r == CS_DIV && div_done) begin
      out_data_r.distance_cm <= dist_sat;
      out_data_r.status      <= range_status(dist_sat, max_cm_r);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/uer_chk.sv
// ----------------------------------------------------------------------------
// uer_chk: port-level checks of the ultrasonic echo ranger
// Result channel behavior over time, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_chk (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire uer_pkg::uer_out_t out_data
);

  // a held result may not change under a stall
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |->
      out_data.status == uer_pkg::STAT_OK && out_data.distance_cm == '0 &&
      out_data.echo_width_us == '0)
    else $error("measurement fields set without done");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res && !out_data.trigger_level)
    else $error("done tick shows busy or trigger");

  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == uer_pkg::STAT_TIMEOUT |->
      out_data.done_res && out_data.distance_cm == '0 && out_data.echo_width_us == '0)
    else $error("timeout result carries a measurement");

endmodule

bind ultrasonic_echo_ranger uer_chk u_uer_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
